### hw/rtl/checked_integer_alu_top_macros.svh
// Assertion macros for the checked integer ALU
`ifndef CHECKED_INTEGER_ALU_TOP_MACROS_SVH
`define CHECKED_INTEGER_ALU_TOP_MACROS_SVH

// Check a condition at every clock edge outside reset
`define CHK_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Check a condition in the cycle after a trigger
`define CHK_ASSERT_NEXT(label, trig, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (expr)) \
    else $error(msg);

`endif

### hw/rtl/chk_pkg.sv
package chk_pkg;

  localparam int unsigned WordBits = 64;
  localparam int unsigned DivSteps = WordBits;
  localparam int unsigned DivLat   = DivSteps + 1;
  localparam int unsigned MulLat   = 4;
  localparam int unsigned MulPad   = DivLat - MulLat;

  typedef logic [WordBits-1:0] word_t;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_MOD = 4'd4,
    OP_NEG = 4'd5,
    OP_NOT = 4'd6,
    OP_AND = 4'd7,
    OP_OR  = 4'd8,
    OP_XOR = 4'd9,
    OP_SHL = 4'd10,
    OP_SHR = 4'd11
  } op_e;

  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_OVERFLOW  = 3'd1,
    ERR_DIV_ZERO  = 3'd2,
    ERR_NEG_SHIFT = 3'd3,
    ERR_BIG_SHIFT = 3'd4
  } err_e;

  typedef enum logic [1:0] {
    KIND_SIMPLE = 2'd0,
    KIND_MUL    = 2'd1,
    KIND_DIV    = 2'd2
  } kind_e;

  typedef struct packed {
    logic [3:0]         mode;
    logic signed [63:0] left_operand;
    logic signed [63:0] right_operand;
  } chk_in_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    logic [2:0]         error_code;
  } chk_out_t;

  typedef struct packed {
    word_t      value;
    logic [2:0] err;
  } res_t;

endpackage

### hw/rtl/chk_mul.sv
module chk_mul import chk_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  word_t mag_a_i,
  input  word_t mag_b_i,
  input  logic  neg_i,
  output res_t  res_o
);

  logic [63:0]  ll_q, lh_q, hl_q, hh_q;
  logic         neg1_q, neg2_q, neg3_q;
  logic [64:0]  mid_q;
  logic [63:0]  ll2_q, hh2_q;
  logic [127:0] prod_q;
  res_t         res_q;
  logic         ovf;

  assign ovf = (|prod_q[127:64]) || (prod_q[63] && (!neg3_q || (|prod_q[62:0])));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q   <= mag_a_i[31:0]  * mag_b_i[31:0];
      lh_q   <= mag_a_i[31:0]  * mag_b_i[63:32];
      hl_q   <= mag_a_i[63:32] * mag_b_i[31:0];
      hh_q   <= mag_a_i[63:32] * mag_b_i[63:32];
      neg1_q <= neg_i;
      mid_q  <= {1'b0, lh_q} + {1'b0, hl_q};
      ll2_q  <= ll_q;
      hh2_q  <= hh_q;
      neg2_q <= neg1_q;
      prod_q <= {hh2_q, 64'd0} + {31'd0, mid_q, 32'd0} + {64'd0, ll2_q};
      neg3_q <= neg2_q;
      if (ovf) begin
        res_q.value <= '0;
        res_q.err   <= ERR_OVERFLOW;
      end else begin
        res_q.value <= neg3_q ? (~prod_q[63:0] + 64'd1) : prod_q[63:0];
        res_q.err   <= ERR_OK;
      end
    end
  end

  assign res_o = res_q;

endmodule

### hw/rtl/chk_div.sv
module chk_div import chk_pkg::*; (
  input  logic       clk_i,
  input  logic       en_i,
  input  word_t      mag_a_i,
  input  word_t      mag_b_i,
  input  logic       qneg_i,
  input  logic       rneg_i,
  input  logic       is_mod_i,
  input  logic [2:0] err_i,
  output res_t       res_o
);

  typedef struct packed {
    word_t      rem;
    word_t      quo;
    word_t      dsr;
    logic       qneg;
    logic       rneg;
    logic       is_mod;
    logic [2:0] err;
  } step_t;

  function automatic step_t div_step(step_t s);
    step_t      n;
    logic [64:0] t;
    logic [64:0] d;
    n = s;
    t = {s.rem, s.quo[63]};
    d = t - {1'b0, s.dsr};
    if (!d[64]) begin
      n.rem = d[63:0];
      n.quo = {s.quo[62:0], 1'b1};
    end else begin
      n.rem = t[63:0];
      n.quo = {s.quo[62:0], 1'b0};
    end
    return n;
  endfunction

  step_t st_q [DivSteps];
  step_t init;
  step_t last;
  res_t  res_q;

  always_comb begin
    init.rem    = '0;
    init.quo    = mag_a_i;
    init.dsr    = mag_b_i;
    init.qneg   = qneg_i;
    init.rneg   = rneg_i;
    init.is_mod = is_mod_i;
    init.err    = err_i;
  end

  assign last = st_q[DivSteps-1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= div_step(init);
      for (int i = 1; i < DivSteps; i++) begin
        st_q[i] <= div_step(st_q[i-1]);
      end
      res_q.err <= last.err;
      if (last.err != ERR_OK) begin
        res_q.value <= '0;
      end else if (last.is_mod) begin
        res_q.value <= last.rneg ? (~last.rem + 64'd1) : last.rem;
      end else begin
        res_q.value <= last.qneg ? (~last.quo + 64'd1) : last.quo;
      end
    end
  end

  assign res_o = res_q;

endmodule

### hw/rtl/checked_integer_alu_top.sv
// Checked 64-bit signed ALU.
// Input channel in_valid_i/in_ready_o carries one operation: mode,
// left_operand, right_operand. Output channel out_valid_o/out_ready_i
// returns one result per operation, in order: result_value and
// error_code; result_value is zero whenever error_code is not zero.
// The path from the accepting edge to out_valid_o is set by the 64-stage
// restoring divider (one quotient bit per stage) plus input, decode,
// sign fix-up and output registers.
// Every operation takes the same path length, so order is kept.
// Throughput: one operation per cycle while the output side takes results.
// Stall: when a result waits and out_ready_i is low, the whole pipeline
// holds and in_ready_o drops; nothing is lost or repeated.
// Reset: asynchronous active-low rst_ni empties the pipeline; no valid
// result is shown and in_ready_o is high once reset is released.
module checked_integer_alu_top import chk_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  chk_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output chk_out_t out_data_o
);

  typedef struct packed {
    kind_e      kind;
    word_t      sres;
    logic [2:0] serr;
  } side_t;

  logic     en;
  logic     v1_q, v2_q;
  chk_in_t  s1_q;
  side_t    side_d, side2_q;
  word_t    ma_d, mb_d, ma_q, mb_q;
  logic     sa_q, sb_q, is_mod_q;
  logic [2:0] derr_d, derr_q;

  logic [DivLat-1:0] vld_q;
  side_t  side_q [DivLat];
  res_t   mres_q [MulPad];
  res_t   mul_res, div_res, sel;
  logic   out_valid_q;
  chk_out_t out_q;

  word_t ua, ub, sum, dif, shl_v, shr_v;
  logic [5:0] sh;
  logic big, lovf;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  assign ua    = s1_q.left_operand;
  assign ub    = s1_q.right_operand;
  assign sum   = ua + ub;
  assign dif   = ua - ub;
  assign sh    = ub[5:0];
  assign big   = |ub[62:6];
  assign shl_v = ua << sh;
  assign shr_v = word_t'($signed(ua) >>> sh);
  assign lovf  = !ua[63] && ((ua >> (6'd63 - sh)) != '0);
  assign ma_d  = ua[63] ? (~ua + 64'd1) : ua;
  assign mb_d  = ub[63] ? (~ub + 64'd1) : ub;

  always_comb begin
    side_d.kind = KIND_SIMPLE;
    side_d.sres = '0;
    side_d.serr = ERR_OK;
    derr_d      = ERR_OK;
    if (ub == '0) begin
      derr_d = ERR_DIV_ZERO;
    end else if (ua == {1'b1, 63'd0} && ub == '1) begin
      derr_d = ERR_OVERFLOW;
    end
    case (op_e'(s1_q.mode))
      OP_ADD: begin
        if ((ua[63] ^ sum[63]) && (ub[63] ^ sum[63])) side_d.serr = ERR_OVERFLOW;
        else side_d.sres = sum;
      end
      OP_SUB: begin
        if ((ua[63] ^ ub[63]) && (ua[63] ^ dif[63])) side_d.serr = ERR_OVERFLOW;
        else side_d.sres = dif;
      end
      OP_MUL: side_d.kind = KIND_MUL;
      OP_DIV: side_d.kind = KIND_DIV;
      OP_MOD: side_d.kind = KIND_DIV;
      OP_NEG: begin
        if (ua == {1'b1, 63'd0}) side_d.serr = ERR_OVERFLOW;
        else side_d.sres = ~ua + 64'd1;
      end
      OP_NOT: side_d.sres = ~ua;
      OP_AND: side_d.sres = ua & ub;
      OP_OR:  side_d.sres = ua | ub;
      OP_XOR: side_d.sres = ua ^ ub;
      OP_SHL, OP_SHR: begin
        if (ub[63]) side_d.serr = ERR_NEG_SHIFT;
        else if (big) side_d.serr = ERR_BIG_SHIFT;
        else if (op_e'(s1_q.mode) == OP_SHR) side_d.sres = shr_v;
        else if (lovf) side_d.serr = ERR_OVERFLOW;
        else side_d.sres = shl_v;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      vld_q       <= {vld_q[DivLat-2:0], v2_q};
      out_valid_q <= vld_q[DivLat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q     <= in_data_i;
      side2_q  <= side_d;
      ma_q     <= ma_d;
      mb_q     <= mb_d;
      sa_q     <= ua[63];
      sb_q     <= ub[63];
      is_mod_q <= (op_e'(s1_q.mode) == OP_MOD);
      derr_q   <= derr_d;
      side_q[0] <= side2_q;
      for (int i = 1; i < DivLat; i++) begin
        side_q[i] <= side_q[i-1];
      end
      mres_q[0] <= mul_res;
      for (int i = 1; i < MulPad; i++) begin
        mres_q[i] <= mres_q[i-1];
      end
      out_q.result_value <= sel.value;
      out_q.error_code   <= sel.err;
    end
  end

  chk_mul u_mul (
    .clk_i   (clk_i),
    .en_i    (en),
    .mag_a_i (ma_q),
    .mag_b_i (mb_q),
    .neg_i   (sa_q ^ sb_q),
    .res_o   (mul_res)
  );

  chk_div u_div (
    .clk_i    (clk_i),
    .en_i     (en),
    .mag_a_i  (ma_q),
    .mag_b_i  (mb_q),
    .qneg_i   (sa_q ^ sb_q),
    .rneg_i   (sa_q),
    .is_mod_i (is_mod_q),
    .err_i    (derr_q),
    .res_o    (div_res)
  );

  always_comb begin
    case (side_q[DivLat-1].kind)
      KIND_MUL: sel = mres_q[MulPad-1];
      KIND_DIV: sel = div_res;
      default: begin
        sel.value = side_q[DivLat-1].sres;
        sel.err   = side_q[DivLat-1].serr;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### hw/rtl/chk_checker.sv
`include "checked_integer_alu_top_macros.svh"

module chk_checker import chk_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input chk_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input chk_out_t out_data_o
);

  `CHK_ASSERT(a_zero_on_err, !out_valid_o || out_data_o.error_code == ERR_OK || out_data_o.result_value == '0, "nonzero result with error")
  `CHK_ASSERT(a_err_range, !out_valid_o || out_data_o.error_code <= ERR_BIG_SHIFT, "error code out of range")
  `CHK_ASSERT(a_ready_only_stall, in_ready_o || (out_valid_o && !out_ready_i), "input blocked without output stall")
  `CHK_ASSERT_NEXT(a_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "stalled result changed")

endmodule

bind checked_integer_alu_top chk_checker u_chk_checker (.*);
